@@ rtl/sdv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdv_pkg: types, constants and microprogram for the scaled direction vector
// Beat layouts, microword format and the control-store contents.
// ----------------------------------------------------------------------------
package sdv_pkg;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic        [14:0] speed;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } res_t;

  localparam int unsigned PcW  = 4;
  localparam int unsigned CntW = 4;

  // Step addresses
  localparam logic [PcW-1:0] PC_IDLE  = 4'd0;
  localparam logic [PcW-1:0] PC_SQX   = 4'd1;
  localparam logic [PcW-1:0] PC_SQY   = 4'd2;
  localparam logic [PcW-1:0] PC_SUM   = 4'd3;
  localparam logic [PcW-1:0] PC_ROOT  = 4'd4;
  localparam logic [PcW-1:0] PC_LEN   = 4'd5;
  localparam logic [PcW-1:0] PC_MULX  = 4'd6;
  localparam logic [PcW-1:0] PC_DLDX  = 4'd7;
  localparam logic [PcW-1:0] PC_DIVX  = 4'd8;
  localparam logic [PcW-1:0] PC_QX    = 4'd9;
  localparam logic [PcW-1:0] PC_MULY  = 4'd10;
  localparam logic [PcW-1:0] PC_DLDY  = 4'd11;
  localparam logic [PcW-1:0] PC_DIVY  = 4'd12;
  localparam logic [PcW-1:0] PC_QY    = 4'd13;
  localparam logic [PcW-1:0] PC_OUT   = 4'd14;

  localparam logic [CntW-1:0] RootLast = 4'd15;
  localparam logic [CntW-1:0] DivLast  = 4'd14;

  localparam logic [31:0] SqrtTopBit = 32'h4000_0000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SQX,
    OP_SQY,
    OP_SUM,
    OP_ROOT,
    OP_LEN,
    OP_MULX,
    OP_MULY,
    OP_DLD,
    OP_DIV,
    OP_QX,
    OP_QY,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_LOOP,
    JC_ZERO,
    JC_JUMP
  } jc_e;

  typedef struct packed {
    op_e             op;
    jc_e             jc;
    logic [PcW-1:0]  target;
    logic [CntW-1:0] last;
  } uword_t;

  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, jc: JC_JUMP, target: PC_IDLE, last: '0};
    unique case (pc)
      PC_IDLE: w = '{op: OP_NOP,  jc: JC_JUMP, target: PC_IDLE, last: '0};
      PC_SQX:  w = '{op: OP_SQX,  jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_SQY:  w = '{op: OP_SQY,  jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_SUM:  w = '{op: OP_SUM,  jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_ROOT: w = '{op: OP_ROOT, jc: JC_LOOP, target: PC_ROOT, last: RootLast};
      PC_LEN:  w = '{op: OP_LEN,  jc: JC_ZERO, target: PC_OUT,  last: '0};
      PC_MULX: w = '{op: OP_MULX, jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_DLDX: w = '{op: OP_DLD,  jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_DIVX: w = '{op: OP_DIV,  jc: JC_LOOP, target: PC_DIVX, last: DivLast};
      PC_QX:   w = '{op: OP_QX,   jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_MULY: w = '{op: OP_MULY, jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_DLDY: w = '{op: OP_DLD,  jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_DIVY: w = '{op: OP_DIV,  jc: JC_LOOP, target: PC_DIVY, last: DivLast};
      PC_QY:   w = '{op: OP_QY,   jc: JC_NEXT, target: PC_IDLE, last: '0};
      PC_OUT:  w = '{op: OP_OUT,  jc: JC_JUMP, target: PC_IDLE, last: '0};
      default: w = '{op: OP_NOP,  jc: JC_JUMP, target: PC_IDLE, last: '0};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/scaled_direction_vector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_direction_vector: scale a 2-D direction to a requested speed
// Length by digit-by-digit square root, per-axis scale by restoring divide.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i and pulse start_i; the beat is taken on a
//   rising edge with start_i high and busy_o low. busy_o stays high until the
//   result is issued, so one command is in flight at a time.
//   Result channel: valid_o is high for exactly one cycle with res_o; the
//   receiver must take it then, there is no back-pressure.
//   Sequencing: one microprogram step per cycle, with 16 root iterations and
//   two 15-step restoring divisions through one shared 16x16 multiplier; a
//   zero-length direction skips the divisions and goes straight to the
//   result. busy_o is low in the strobe cycle, so the next command can be
//   taken in that cycle.
//   Components are taken as COORD_BITS-wide two's complement values.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
//   valid_o; any command in flight is lost.
// ----------------------------------------------------------------------------
module scaled_direction_vector #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sdv_pkg::cmd_t       cmd_i,
  output logic                busy_o,
  output logic                valid_o,
  output sdv_pkg::res_t       res_o
);

  localparam int unsigned ExtW = 17;

  // Control
  logic [sdv_pkg::PcW-1:0]  pc_q, pc_d;
  logic [sdv_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     valid_q, valid_d;
  sdv_pkg::uword_t          uw;
  logic                     take;

  // Datapath
  logic               sx_q, sy_q;
  logic [15:0]        ax_q, ay_q;
  logic [14:0]        spd_q;
  logic [31:0]        prod_q, rad_q, acc_q, bit_q;
  logic [15:0]        len_q, drem_q;
  logic [14:0]        dlo_q, qx_q, qy_q;
  sdv_pkg::res_t      res_q;

  logic [COORD_BITS-1:0] cx, cy;
  logic [ExtW-1:0]       ext_x, ext_y, neg_x, neg_y;
  logic [15:0]           mag_x, mag_y;
  logic [15:0]           mul_a, mul_b;
  logic [31:0]           prod_d;
  logic [32:0]           root_trial;
  logic                  root_ge;
  logic [16:0]           div_trial;
  logic                  div_ge;

  assign uw   = sdv_pkg::ucode(pc_q);
  assign take = start_i && (pc_q == sdv_pkg::PC_IDLE);

  // Input sign extension and magnitude
  assign cx    = cmd_i.dir_x[COORD_BITS-1:0];
  assign cy    = cmd_i.dir_y[COORD_BITS-1:0];
  assign ext_x = {{(ExtW-COORD_BITS){cx[COORD_BITS-1]}}, cx};
  assign ext_y = {{(ExtW-COORD_BITS){cy[COORD_BITS-1]}}, cy};
  assign neg_x = ExtW'(0) - ext_x;
  assign neg_y = ExtW'(0) - ext_y;
  assign mag_x = cx[COORD_BITS-1] ? neg_x[15:0] : ext_x[15:0];
  assign mag_y = cy[COORD_BITS-1] ? neg_y[15:0] : ext_y[15:0];

  // Shared multiplier
  always_comb begin
    unique case (uw.op)
      sdv_pkg::OP_SQX:  begin mul_a = ax_q; mul_b = ax_q;            end
      sdv_pkg::OP_SQY:  begin mul_a = ay_q; mul_b = ay_q;            end
      sdv_pkg::OP_MULX: begin mul_a = ax_q; mul_b = {1'b0, spd_q};   end
      sdv_pkg::OP_MULY: begin mul_a = ay_q; mul_b = {1'b0, spd_q};   end
      default:          begin mul_a = ax_q; mul_b = {1'b0, spd_q};   end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // Square root step and restoring divide step
  assign root_trial = {1'b0, acc_q} + {1'b0, bit_q};
  assign root_ge    = {1'b0, rad_q} >= root_trial;
  assign div_trial  = {drem_q, dlo_q[14]};
  assign div_ge     = div_trial >= {1'b0, len_q};

  // Sequencer
  always_comb begin
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    if (pc_q == sdv_pkg::PC_IDLE) begin
      if (start_i) pc_d = sdv_pkg::PC_SQX;
    end else begin
      unique case (uw.jc)
        sdv_pkg::JC_NEXT: pc_d = pc_q + 1'b1;
        sdv_pkg::JC_LOOP: pc_d = (cnt_q != uw.last) ? uw.target : pc_q + 1'b1;
        sdv_pkg::JC_ZERO: pc_d = (acc_q == '0) ? uw.target : pc_q + 1'b1;
        sdv_pkg::JC_JUMP: pc_d = uw.target;
        default:          pc_d = sdv_pkg::PC_IDLE;
      endcase
      unique case (uw.op)
        sdv_pkg::OP_SUM, sdv_pkg::OP_DLD: cnt_d = '0;
        sdv_pkg::OP_ROOT, sdv_pkg::OP_DIV: cnt_d = cnt_q + 1'b1;
        sdv_pkg::OP_OUT:                  valid_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= sdv_pkg::PC_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sx_q  <= cx[COORD_BITS-1];
      sy_q  <= cy[COORD_BITS-1];
      ax_q  <= mag_x;
      ay_q  <= mag_y;
      spd_q <= cmd_i.speed;
    end
    unique case (uw.op)
      sdv_pkg::OP_SQX:  prod_q <= prod_d;
      sdv_pkg::OP_SQY: begin
        rad_q  <= prod_q;
        prod_q <= prod_d;
      end
      sdv_pkg::OP_SUM: begin
        rad_q <= rad_q + prod_q;
        acc_q <= '0;
        bit_q <= sdv_pkg::SqrtTopBit;
      end
      sdv_pkg::OP_ROOT: begin
        if (root_ge) begin
          rad_q <= rad_q - root_trial[31:0];
          acc_q <= (acc_q >> 1) + bit_q;
        end else begin
          acc_q <= acc_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      sdv_pkg::OP_LEN: begin
        len_q <= acc_q[15:0];
        qx_q  <= '0;
        qy_q  <= '0;
      end
      sdv_pkg::OP_MULX, sdv_pkg::OP_MULY: prod_q <= prod_d;
      sdv_pkg::OP_DLD: begin
        drem_q <= prod_q[30:15];
        dlo_q  <= prod_q[14:0];
      end
      sdv_pkg::OP_DIV: begin
        drem_q <= div_ge ? 16'(div_trial - {1'b0, len_q}) : div_trial[15:0];
        dlo_q  <= {dlo_q[13:0], div_ge};
      end
      sdv_pkg::OP_QX: qx_q <= dlo_q;
      sdv_pkg::OP_QY: qy_q <= dlo_q;
      sdv_pkg::OP_OUT: begin
        res_q.vel_x <= sx_q ? 16'(16'd0 - {1'b0, qx_q}) : {1'b0, qx_q};
        res_q.vel_y <= sy_q ? 16'(16'd0 - {1'b0, qy_q}) : {1'b0, qy_q};
      end
      default: ;
    endcase
  end

  assign busy_o  = (pc_q != sdv_pkg::PC_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTH
  a_strobe_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not start sequencer");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_bounded_by_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((qx_q <= spd_q) && (qy_q <= spd_q)))
    else $error("scaled component exceeds speed");

  a_loop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == sdv_pkg::OP_DIV) |-> (cnt_q <= sdv_pkg::DivLast))
    else $error("divide loop overran");
`endif

endmodule

@@ bench/scaled_direction_vector_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_direction_vector_test: self-checking bench for scaled_direction_vector
// Drives directed and random direction/speed commands, predicts each velocity
// with an integer square root and a truncating divide, and compares every
// result strobe against the oldest prediction. Sender idling varies by phase.
// ----------------------------------------------------------------------------
module scaled_direction_vector_test;

  localparam int unsigned CoordBits  = 16;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainWait  = 60;

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          start_i = 1'b0;
  sdv_pkg::cmd_t cmd_i   = '0;
  logic          busy_o;
  logic          valid_o;
  sdv_pkg::res_t res_o;

  sdv_pkg::res_t expected_vel[$];
  int unsigned   mismatches      = 0;
  int unsigned   stall_cycles    = 0;
  int unsigned   sender_idle_pct = 0;

  scaled_direction_vector #(
    .COORD_BITS(CoordBits)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic signed [31:0] coord_value(logic [15:0] raw);
    logic [31:0] v;
    v = {16'b0, raw} << (32 - CoordBits);
    return $signed(v) >>> (32 - CoordBits);
  endfunction

  function automatic logic [31:0] isqrt_floor(logic [31:0] n);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] b;
    rem  = n;
    root = '0;
    b    = 32'h4000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = root + (b << 1);
      end
      root = root >> 1;
      b    = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] scale_axis(logic signed [31:0] comp, logic [14:0] spd,
                                             logic [31:0] len);
    logic [31:0] mag;
    logic [63:0] q;
    logic [15:0] r;
    mag = (comp < 0) ? 32'(-comp) : 32'(comp);
    q   = (64'(mag) * 64'(spd)) / 64'(len);
    r   = q[15:0];
    if (comp < 0) r = -r;
    return r;
  endfunction

  function automatic sdv_pkg::res_t scaled_velocity(sdv_pkg::cmd_t c);
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        len;
    sdv_pkg::res_t      r;
    dx  = coord_value(c.dir_x);
    dy  = coord_value(c.dir_y);
    ax  = (dx < 0) ? 32'(-dx) : 32'(dx);
    ay  = (dy < 0) ? 32'(-dy) : 32'(dy);
    len = isqrt_floor(ax * ax + ay * ay);
    r   = '0;
    if (len != 0) begin
      r.vel_x = scale_axis(dx, c.speed, len);
      r.vel_y = scale_axis(dy, c.speed, len);
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // start_i is only lowered when a gap is taken, so back-to-back beats never
  // see two assignments to it in one step
  task automatic send_cmd(sdv_pkg::cmd_t c);
    int unsigned gap;
    if (sender_idle_pct != 0) begin
      if ($urandom_range(2) == 0) begin
        gap = $urandom_range(70);
        if (gap != 0) begin
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else if ($urandom_range(99) < sender_idle_pct) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
      end
    end
    cmd_i   <= c;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_vel = {expected_vel, scaled_velocity(c)};
  endtask

  function automatic sdv_pkg::cmd_t make_cmd(logic [15:0] x, logic [15:0] y, logic [14:0] s);
    sdv_pkg::cmd_t c;
    c.dir_x = x;
    c.dir_y = y;
    c.speed = s;
    return c;
  endfunction

  function automatic sdv_pkg::cmd_t random_cmd();
    sdv_pkg::cmd_t c;
    int unsigned   kind;
    kind    = $urandom_range(9);
    c.dir_x = 16'($urandom);
    c.dir_y = 16'($urandom);
    c.speed = 15'($urandom);
    case (kind)
      0, 1: begin
        c.dir_x = 16'(int'($urandom_range(16)) - 8);
        c.dir_y = 16'(int'($urandom_range(16)) - 8);
      end
      2: begin
        if ($urandom_range(1)) c.dir_x = '0;
        else c.dir_y = '0;
      end
      3: begin
        c.dir_x = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        if ($urandom_range(1)) c.dir_y = $urandom_range(1) ? 16'h8000 : 16'h8001;
      end
      4: c.speed = $urandom_range(1) ? 15'h7FFF : 15'h0000;
      5: begin
        c.dir_x = '0;
        c.dir_y = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic test_zero_length();
    send_cmd(make_cmd(16'h0000, 16'h0000, 15'h0000));
    send_cmd(make_cmd(16'h0000, 16'h0000, 15'h7FFF));
    send_cmd(make_cmd(16'h0000, 16'h0000, 15'h0001));
  endtask

  task automatic test_extreme_components();
    send_cmd(make_cmd(16'h8000, 16'h8000, 15'h7FFF));
    send_cmd(make_cmd(16'h8000, 16'h0000, 15'h7FFF));
    send_cmd(make_cmd(16'h0000, 16'h8000, 15'h7FFF));
    send_cmd(make_cmd(16'h7FFF, 16'h7FFF, 15'h7FFF));
    send_cmd(make_cmd(16'h7FFF, 16'h8000, 15'h5555));
    send_cmd(make_cmd(16'h8000, 16'h7FFF, 15'h2AAA));
    send_cmd(make_cmd(16'h8001, 16'h7FFF, 15'h7FFF));
    send_cmd(make_cmd(16'h0001, 16'h0000, 15'h7FFF));
    send_cmd(make_cmd(16'hFFFF, 16'h0000, 15'h7FFF));
    send_cmd(make_cmd(16'h0000, 16'hFFFF, 15'h0001));
    send_cmd(make_cmd(16'h0001, 16'h0001, 15'h7FFF));
    send_cmd(make_cmd(16'hFFFF, 16'hFFFF, 15'h7FFF));
    send_cmd(make_cmd(16'h0003, 16'hFFFC, 15'h0005));
    send_cmd(make_cmd(16'h1234, 16'hEDCB, 15'h0000));
    send_cmd(make_cmd(16'h8000, 16'h8000, 15'h0000));
    send_cmd(make_cmd(16'h5555, 16'hAAAA, 15'h5555));
  endtask

  task automatic test_random_vectors(int unsigned count, int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_cmd(random_cmd());
  endtask

  always @(posedge clk_i) begin
    sdv_pkg::res_t exp_r;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_vel.size() == 0) begin
        report_mismatch($sformatf("unexpected result vel_x=%0d vel_y=%0d",
                                  res_o.vel_x, res_o.vel_y));
      end else begin
        exp_r = expected_vel.pop_front();
        if (res_o.vel_x !== exp_r.vel_x)
          report_mismatch($sformatf("vel_x got %0d exp %0d", res_o.vel_x, exp_r.vel_x));
        if (res_o.vel_y !== exp_r.vel_y)
          report_mismatch($sformatf("vel_y got %0d exp %0d", res_o.vel_y, exp_r.vel_y));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || valid_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_length();
    test_extreme_components();
    test_random_vectors(300, 0);
    test_random_vectors(300, 88);
    test_random_vectors(250, 0);
    test_random_vectors(300, 32);

    start_i <= 1'b0;
    while (expected_vel.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
